// File: rtl/srit_pkg.sv
// Shared types and constants for the segment versus rectangle crossing test.
package srit_pkg;

    localparam int FIELD_W    = 32;
    localparam int CFG_ADDR_W = 4;

    localparam logic [CFG_ADDR_W-1:0] REG_MIN_X = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_X = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_Y = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_Y = 4'd3;

    typedef struct packed {
        logic signed [FIELD_W-1:0] min_x;
        logic signed [FIELD_W-1:0] max_x;
        logic signed [FIELD_W-1:0] min_y;
        logic signed [FIELD_W-1:0] max_y;
    } rect_t;

    typedef struct packed {
        logic valid;
        logic ok;
    } stage_ctl_t;

endpackage

// File: rtl/srit_cfg.sv
// Rectangle bound registers written through the configuration channel.
module srit_cfg
    import srit_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [FIELD_W-1:0]    cfg_data,
    output rect_t                 rect
);

    rect_t rect_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_reg <= '0;
        end
        else if (cfg_valid)
        begin
            // Writes to indexes past the last bound are dropped.
            unique case (cfg_addr)
                REG_MIN_X: rect_reg.min_x <= cfg_data;
                REG_MAX_X: rect_reg.max_x <= cfg_data;
                REG_MIN_Y: rect_reg.min_y <= cfg_data;
                REG_MAX_Y: rect_reg.max_y <= cfg_data;
                default:   rect_reg       <= rect_reg;
            endcase
        end
    end

    assign rect = rect_reg;

endmodule

// File: rtl/srit_setup.sv
// First two pipeline stages: edge distances, then per-axis entry and exit ratios.
module srit_setup
    import srit_pkg::*;
#(
    parameter int COORD_BITS = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [FIELD_W-1:0]      start_x,
    input  logic [FIELD_W-1:0]      start_y,
    input  logic [FIELD_W-1:0]      end_x,
    input  logic [FIELD_W-1:0]      end_y,
    input  rect_t                   rect,
    output stage_ctl_t              ctl,
    output logic signed [COORD_BITS:0] ax,
    output logic signed [COORD_BITS:0] bx,
    output logic signed [COORD_BITS:0] dxa,
    output logic signed [COORD_BITS:0] ay,
    output logic signed [COORD_BITS:0] by,
    output logic signed [COORD_BITS:0] dya
);

    localparam int CW = COORD_BITS;
    localparam int W  = COORD_BITS + 1;

    // Low CW bits of a field, read as two's complement; a field narrower
    // than CW is zero-extended first.
    function automatic logic signed [W-1:0] to_coord(input logic [FIELD_W-1:0] v);
        logic [CW+FIELD_W-1:0] wide;
        logic [CW-1:0]         c;
        wide = {{CW{1'b0}}, v};
        c    = wide[CW-1:0];
        return {c[CW-1], c};
    endfunction

    // Stage 1: differences at full width.
    logic                v1_reg;
    logic signed [W-1:0] q0_reg, q1_reg, q2_reg, q3_reg, dx_reg, dy_reg;
    logic signed [W-1:0] sx, sy, ex, ey;

    assign sx = to_coord(start_x);
    assign sy = to_coord(start_y);
    assign ex = to_coord(end_x);
    assign ey = to_coord(end_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= sx - to_coord(rect.min_x);
        q1_reg <= to_coord(rect.max_x) - sx;
        q2_reg <= sy - to_coord(rect.min_y);
        q3_reg <= to_coord(rect.max_y) - sy;
        dx_reg <= ex - sx;
        dy_reg <= ey - sy;
    end

    // Stage 2: pick the entering and leaving edge of each axis. Both share
    // the denominator |d|. A parallel axis is neutral (ratios 0 and 1) and
    // only requires the segment to lie between both edges of that axis.
    logic signed [W-1:0] ax_next, bx_next, dxa_next, ay_next, by_next, dya_next;
    logic                okx, oky;

    always_comb
    begin
        if (dx_reg == '0)
        begin
            ax_next  = '0;
            bx_next  = W'(1);
            dxa_next = W'(1);
            okx      = !q0_reg[CW] && !q1_reg[CW];
        end
        else if (!dx_reg[CW])
        begin
            ax_next  = -q0_reg;
            bx_next  = q1_reg;
            dxa_next = dx_reg;
            okx      = 1'b1;
        end
        else
        begin
            ax_next  = -q1_reg;
            bx_next  = q0_reg;
            dxa_next = -dx_reg;
            okx      = 1'b1;
        end

        if (dy_reg == '0)
        begin
            ay_next  = '0;
            by_next  = W'(1);
            dya_next = W'(1);
            oky      = !q2_reg[CW] && !q3_reg[CW];
        end
        else if (!dy_reg[CW])
        begin
            ay_next  = -q2_reg;
            by_next  = q3_reg;
            dya_next = dy_reg;
            oky      = 1'b1;
        end
        else
        begin
            ay_next  = -q3_reg;
            by_next  = q2_reg;
            dya_next = -dy_reg;
            oky      = 1'b1;
        end
    end

    stage_ctl_t ctl_reg;
    logic signed [W-1:0] ax_reg, bx_reg, dxa_reg, ay_reg, by_reg, dya_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg.valid <= v1_reg;
            ctl_reg.ok    <= okx && oky;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg  <= ax_next;
        bx_reg  <= bx_next;
        dxa_reg <= dxa_next;
        ay_reg  <= ay_next;
        by_reg  <= by_next;
        dya_reg <= dya_next;
    end

    assign ctl = ctl_reg;
    assign ax  = ax_reg;
    assign bx  = bx_reg;
    assign dxa = dxa_reg;
    assign ay  = ay_reg;
    assign by  = by_reg;
    assign dya = dya_reg;

endmodule

// File: rtl/srit_cross.sv
// Last two pipeline stages: cross products of the ratios, then the final interval test.
module srit_cross
    import srit_pkg::*;
#(
    parameter int COORD_BITS = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  stage_ctl_t                 ctl,
    input  logic signed [COORD_BITS:0] ax,
    input  logic signed [COORD_BITS:0] bx,
    input  logic signed [COORD_BITS:0] dxa,
    input  logic signed [COORD_BITS:0] ay,
    input  logic signed [COORD_BITS:0] by,
    input  logic signed [COORD_BITS:0] dya,
    output logic                       done,
    output logic                       crosses
);

    localparam int W = COORD_BITS + 1;
    localparam int P = 2 * W;

    // Stage 3: the four cross products, plus the tests that need no product.
    // The interval is nonempty exactly when every entering ratio (and 0) is
    // at most every leaving ratio (and 1).
    stage_ctl_t          ctl3_reg;
    logic signed [P-1:0] m0_reg, m1_reg, m2_reg, m3_reg;
    logic                lin_ok;

    assign lin_ok = !bx[W-1] && (ax <= dxa) && (ax <= bx) &&
                    !by[W-1] && (ay <= dya) && (ay <= by);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl3_reg <= '0;
        end
        else
        begin
            ctl3_reg.valid <= ctl.valid;
            ctl3_reg.ok    <= ctl.ok && lin_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        m0_reg <= ax * dya;
        m1_reg <= by * dxa;
        m2_reg <= ay * dxa;
        m3_reg <= bx * dya;
    end

    // Stage 4: compare the entry ratio of each axis with the exit of the other.
    logic done_reg, crosses_reg;
    logic crosses_next;

    assign crosses_next = ctl3_reg.valid && ctl3_reg.ok &&
                          (m0_reg <= m1_reg) && (m2_reg <= m3_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg    <= 1'b0;
            crosses_reg <= 1'b0;
        end
        else
        begin
            done_reg    <= ctl3_reg.valid;
            crosses_reg <= crosses_next;
        end
    end

    assign done    = done_reg;
    assign crosses = crosses_reg;

endmodule

// File: rtl/segment_rectangle_intersect_test_core.sv
// Top level of the pipelined segment versus rectangle crossing test.
//
// Usage: the rectangle bounds are written through the configuration channel
// (cfg_valid, cfg_ready, cfg_addr, cfg_data), index 0 left, 1 right,
// 2 bottom, 3 top; cfg_ready is always high and other indexes are ignored.
// Bounds should only change while no word is in flight.
// A segment word is taken at every rising edge where start is high; busy is
// always low, so one word may enter in every cycle and the block sustains
// one word per cycle.
// The answer appears on crosses together with a one-cycle done strobe. A
// word accepted at an edge passes one registered stage of edge distances,
// one of ratio selection, one of cross products (four multipliers of
// COORD_BITS+1 bits), and one final compare before it is delivered.
// Results leave in acceptance order; the receiver has no way to stall the
// pipeline, so it must take each word in its strobe cycle.
// Reset clears every pipeline valid bit, so nothing is delivered that was in
// flight, and all four bounds return to zero.
module segment_rectangle_intersect_test_core
    import srit_pkg::*;
#(
    parameter int COORD_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [FIELD_W-1:0]    start_x,
    input  logic [FIELD_W-1:0]    start_y,
    input  logic [FIELD_W-1:0]    end_x,
    input  logic [FIELD_W-1:0]    end_y,
    output logic                  done,
    output logic                  crosses,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [FIELD_W-1:0]    cfg_data
);

    rect_t                       rect;
    stage_ctl_t                  ctl;
    logic signed [COORD_BITS:0]  ax, bx, dxa, ay, by, dya;

    // The pipeline never stalls, so both channels are always open.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    srit_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .rect      (rect)
    );

    srit_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .start_x  (start_x),
        .start_y  (start_y),
        .end_x    (end_x),
        .end_y    (end_y),
        .rect     (rect),
        .ctl      (ctl),
        .ax       (ax),
        .bx       (bx),
        .dxa      (dxa),
        .ay       (ay),
        .by       (by),
        .dya      (dya)
    );

    srit_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .ax      (ax),
        .bx      (bx),
        .dxa     (dxa),
        .ay      (ay),
        .by      (by),
        .dya     (dya),
        .done    (done),
        .crosses (crosses)
    );

    // Every delivered word matches a word accepted earlier at the pipeline input.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result strobe without a matching accepted word");

    // The answer bit is quiet outside its strobe cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> !crosses)
        else $error("crosses high outside a result cycle");

    // A word entering in the middle stage always reaches the output stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.valid |-> ##2 done)
        else $error("word lost between pipeline stages");

endmodule

// File: verif/segment_rectangle_intersect_test_core_tb.sv
// Self-checking testbench for the pipelined segment versus rectangle crossing test.
`timescale 1ns / 100ps

module segment_rectangle_intersect_test_core_tb
    import srit_pkg::*;
();

    localparam int     CYCLE_LIMIT  = 200000;
    localparam int     DRAIN_CYCLES = 8;
    localparam int     RANDOM_SETS  = 10;
    localparam int     SEGS_PER_SET = 100;
    localparam longint COORD_MIN    = -64'sd2147483648;
    localparam longint COORD_MAX    = 64'sd2147483647;

    // Bounds of the directed rectangle: +-100 mm by +-50 mm in Q16.16.
    localparam logic [FIELD_W-1:0] XB = 32'h0064_0000;
    localparam logic [FIELD_W-1:0] YB = 32'h0032_0000;

    typedef logic signed [127:0] prod_t;

    typedef struct packed {
        logic [FIELD_W-1:0] sx;
        logic [FIELD_W-1:0] sy;
        logic [FIELD_W-1:0] ex;
        logic [FIELD_W-1:0] ey;
    } seg_t;

    typedef struct packed {
        logic [CFG_ADDR_W-1:0] addr;
        logic [FIELD_W-1:0]    data;
    } cfg_word_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    logic [FIELD_W-1:0]    start_x   = '0;
    logic [FIELD_W-1:0]    start_y   = '0;
    logic [FIELD_W-1:0]    end_x     = '0;
    logic [FIELD_W-1:0]    end_y     = '0;
    logic                  done;
    logic                  crosses;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [FIELD_W-1:0]    cfg_data  = '0;

    seg_t  pending_segs[$];
    logic  expected_crosses[$];
    rect_t bounds_model = '0;
    seg_t  cur_seg;
    logic  want_cross;
    int    sender_idle_pct = 0;
    int    cycle_count     = 0;
    int    mismatch_count  = 0;
    int    words_sent      = 0;
    int    results_seen    = 0;
    int    hits_seen       = 0;
    int    settings_count  = 1;

    segment_rectangle_intersect_test_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .done      (done),
        .crosses   (crosses),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Sign of a*b - c*d, exact at 128 bits.
    function automatic int cross_sign(longint a, longint b, longint c, longint d);
        prod_t lhs;
        prod_t rhs;
        lhs = prod_t'(a) * prod_t'(b);
        rhs = prod_t'(c) * prod_t'(d);
        if (lhs < rhs)
            return -1;
        if (lhs > rhs)
            return 1;
        return 0;
    endfunction

    // Clips the interval [0,1] against left, right, bottom and top in turn,
    // with each bound held as a fraction whose denominator is positive.
    function automatic logic predict_crossing(rect_t r, seg_t s);
        longint sx, sy, dx, dy, num, den, n0, d0, n1, d1;
        longint p[4];
        longint q[4];
        sx = longint'($signed(s.sx));
        sy = longint'($signed(s.sy));
        dx = longint'($signed(s.ex)) - sx;
        dy = longint'($signed(s.ey)) - sy;
        p[0] = -dx; q[0] = sx - longint'(r.min_x);
        p[1] = dx;  q[1] = longint'(r.max_x) - sx;
        p[2] = -dy; q[2] = sy - longint'(r.min_y);
        p[3] = dy;  q[3] = longint'(r.max_y) - sy;
        n0 = 0; d0 = 1; n1 = 1; d1 = 1;
        for (int i = 0; i < 4; i++)
        begin
            if (p[i] == 0)
            begin
                if (q[i] < 0)
                    return 1'b0;
            end
            else if (p[i] < 0)
            begin
                num = -q[i];
                den = -p[i];
                if (cross_sign(num, d1, n1, den) > 0)
                    return 1'b0;
                if (cross_sign(num, d0, n0, den) > 0)
                begin
                    n0 = num;
                    d0 = den;
                end
            end
            else
            begin
                num = q[i];
                den = p[i];
                if (cross_sign(num, d0, n0, den) < 0)
                    return 1'b0;
                if (cross_sign(num, d1, n1, den) < 0)
                begin
                    n1 = num;
                    d1 = den;
                end
            end
        end
        return cross_sign(n0, d1, n1, d0) <= 0;
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v < COORD_MIN)
            return COORD_MIN;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    function automatic rect_t random_rect();
        rect_t  r;
        longint c, h;
        logic [FIELD_W-1:0] lo, hi;
        c = longint'($signed($urandom));
        h = longint'($urandom >> $urandom_range(0, 31));
        lo = FIELD_W'(clamp_coord(c - h));
        hi = FIELD_W'(clamp_coord(c + h));
        if ($urandom_range(0, 9) == 0)
            {r.min_x, r.max_x} = {hi, lo};
        else
            {r.min_x, r.max_x} = {lo, hi};
        c = longint'($signed($urandom));
        h = longint'($urandom >> $urandom_range(0, 31));
        lo = FIELD_W'(clamp_coord(c - h));
        hi = FIELD_W'(clamp_coord(c + h));
        if ($urandom_range(0, 9) == 0)
            {r.min_y, r.max_y} = {hi, lo};
        else
            {r.min_y, r.max_y} = {lo, hi};
        return r;
    endfunction

    // A coordinate on, just beside, inside or far from the span [lo, hi].
    function automatic logic [FIELD_W-1:0] pick_near(longint lo, longint hi);
        longint span, v;
        span = hi - lo + 1;
        case ($urandom_range(0, 8))
            0:       v = lo;
            1:       v = hi;
            2:       v = lo - 1;
            3:       v = hi + 1;
            4:       v = lo - $urandom_range(1, 1000);
            5:       v = hi + $urandom_range(1, 1000);
            6:       v = longint'($signed($urandom));
            default:
            begin
                if (span > 0)
                    v = lo + (longint'($urandom) % span);
                else
                    v = longint'($signed($urandom));
            end
        endcase
        return v[FIELD_W-1:0];
    endfunction

    function automatic seg_t random_segment(rect_t r);
        seg_t s;
        s.sx = pick_near(r.min_x, r.max_x);
        s.sy = pick_near(r.min_y, r.max_y);
        s.ex = pick_near(r.min_x, r.max_x);
        s.ey = pick_near(r.min_y, r.max_y);
        case ($urandom_range(0, 9))
            0:       s = {$urandom, $urandom, $urandom, $urandom};
            1:       {s.ex, s.ey} = {s.sx, s.sy};
            2:       s.ex = s.sx;
            3:       s.ey = s.sy;
            default: ;
        endcase
        return s;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("ERROR at cycle %0d: %s", cycle_count, what);
    endtask

    task automatic add_seg(input logic [FIELD_W-1:0] sx, input logic [FIELD_W-1:0] sy,
                           input logic [FIELD_W-1:0] ex, input logic [FIELD_W-1:0] ey);
        seg_t s;
        s = {sx, sy, ex, ey};
        pending_segs.insert(pending_segs.size(), s);
    endtask

    // Returns once every queued segment has been answered and the pipeline
    // has had time to empty.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_segs.size() != 0 || start || expected_crosses.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Writes all four bounds, then a word to an unused index that must not
    // disturb them.
    task automatic write_bounds(input rect_t r);
        cfg_word_t words[$];
        words.insert(words.size(), {REG_MIN_X, r.min_x});
        words.insert(words.size(), {REG_MAX_X, r.max_x});
        words.insert(words.size(), {REG_MIN_Y, r.min_y});
        words.insert(words.size(), {REG_MAX_Y, r.max_y});
        words.insert(words.size(),
                     {CFG_ADDR_W'(REG_MAX_Y + 1 + $urandom_range(0, 11)), $urandom});
        @(posedge clk);
        foreach (words[i])
        begin
            cfg_valid <= 1'b1;
            cfg_addr  <= words[i].addr;
            cfg_data  <= words[i].data;
            do
                @(posedge clk);
            while (!cfg_ready);
            case (words[i].addr)
                REG_MIN_X: bounds_model.min_x = words[i].data;
                REG_MAX_X: bounds_model.max_x = words[i].data;
                REG_MIN_Y: bounds_model.min_y = words[i].data;
                REG_MAX_Y: bounds_model.max_y = words[i].data;
                default:   ;
            endcase
        end
        cfg_valid <= 1'b0;
        settings_count++;
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, expected_crosses.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Driver: a segment word is taken at each edge where start is high and
    // busy is low; the next one is presented at that same edge.
    always @(posedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || !busy)
        begin
            if (start)
            begin
                expected_crosses.insert(expected_crosses.size(),
                                        predict_crossing(bounds_model, cur_seg));
                words_sent++;
            end
            if (pending_segs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                cur_seg = pending_segs.pop_front();
                start   <= 1'b1;
                start_x <= cur_seg.sx;
                start_y <= cur_seg.sy;
                end_x   <= cur_seg.ex;
                end_y   <= cur_seg.ey;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: each done strobe carries exactly one answer.
    always @(posedge clk)
    begin
        if (done === 1'b1)
        begin
            if (expected_crosses.size() == 0)
                report_mismatch("done strobe with no segment outstanding");
            else
            begin
                want_cross = expected_crosses.pop_front();
                results_seen++;
                if (want_cross)
                    hits_seen++;
                if (crosses !== want_cross)
                    report_mismatch($sformatf("result %0d: crosses %b, wanted %b",
                                              results_seen, crosses, want_cross));
            end
        end
    end

    initial
    begin
        rect_t r;
        int idle_levels[3];
        idle_levels = '{0, 69, 13};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset bounds describe a single point at the origin.
        add_seg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001);
        add_seg(32'h0000_0001, 32'h0000_0000, 32'h0000_0002, 32'h0000_0000);
        add_seg(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        wait_drained();

        r.min_x = -XB; r.max_x = XB; r.min_y = -YB; r.max_y = YB;
        write_bounds(r);
        sender_idle_pct = 13;
        add_seg(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000);
        add_seg(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_seg(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        // Segments parallel to an edge and wholly outside it.
        add_seg(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        add_seg(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_seg(32'h8000_0000, YB + 1, 32'h7FFF_FFFF, YB + 1);
        // Parallel segments inside the slab and along the top and left edges.
        add_seg(32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        add_seg(32'h8000_0000, YB, 32'h7FFF_FFFF, YB);
        add_seg(-XB, 32'h7FFF_FFFF, -XB, 32'h8000_0000);
        // Segments that shrink to a point: inside, on a corner, just outside, far outside.
        add_seg(32'h0000_0005, 32'h0000_0005, 32'h0000_0005, 32'h0000_0005);
        add_seg(XB, YB, XB, YB);
        add_seg(XB + 1, 32'h0000_0000, XB + 1, 32'h0000_0000);
        add_seg(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        // Grazing a corner exactly, and missing it by one step.
        add_seg(XB - 1, YB + 1, XB + 1, YB - 1);
        add_seg(XB, YB + 2, XB + 2, YB);
        // Ending just short of the right edge and exactly on it.
        add_seg(XB + 10, 32'h0000_0000, XB + 1, 32'h0000_0000);
        add_seg(XB + 10, 32'h0000_0000, XB, 32'h0000_0000);
        add_seg(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        add_seg(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555);
        wait_drained();

        for (int set = 0; set < RANDOM_SETS; set++)
        begin
            r = random_rect();
            case (set)
                0:
                begin
                    r.min_x = FIELD_W'(COORD_MIN); r.max_x = FIELD_W'(COORD_MAX);
                    r.min_y = FIELD_W'(COORD_MIN); r.max_y = FIELD_W'(COORD_MAX);
                end
                1:
                begin
                    r.min_x = FIELD_W'(COORD_MIN); r.max_x = FIELD_W'(COORD_MIN);
                    r.min_y = FIELD_W'(COORD_MAX); r.max_y = FIELD_W'(COORD_MAX);
                end
                2: {r.min_x, r.max_x} = {r.max_x + 32'd1, r.max_x};
                3: {r.min_y, r.max_y} = {FIELD_W'(COORD_MAX), FIELD_W'(COORD_MIN)};
                default: ;
            endcase
            write_bounds(r);
            sender_idle_pct = idle_levels[set % 3];
            repeat (SEGS_PER_SET)
                pending_segs.insert(pending_segs.size(), random_segment(bounds_model));
            wait_drained();
        end

        if (expected_crosses.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_crosses.size()));
        $display("Sent %0d segment words under %0d rectangle settings.",
                 words_sent, settings_count);
        $display("Checked %0d answers: %0d crossing, %0d clear, %0d mismatches.",
                 results_seen, hits_seen, results_seen - hits_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
